// ----- hw/rtl/lsd_pkg.sv -----
`default_nettype none

package lsd_pkg;

    // Table size and type range.
    localparam int NUM_STATIONS = 16;
    localparam int NUM_TYPES    = 16;
    localparam int STN_W        = (NUM_STATIONS > 1) ? $clog2(NUM_STATIONS) : 1;

    // Field widths.
    localparam int OP_W    = 2;
    localparam int IDX_W   = 4;
    localparam int TYPE_W  = 4;
    localparam int MASK_W  = 16;
    localparam int POS_W   = 16;
    localparam int COUNT_W = 8;

    // Squared distance: three squares of a 16-bit magnitude.
    localparam int SQ_W   = 2 * POS_W;
    localparam int DIST_W = SQ_W + 2;

    // Stream widths, whole bytes.
    localparam int IN_BITS    = IDX_W + 1 + TYPE_W + MASK_W + 3 * POS_W + COUNT_W;
    localparam int S_TDATA_W  = ((IN_BITS + 7) / 8) * 8;
    localparam int S_TUSER_W  = OP_W;
    localparam int OUT_BITS   = IDX_W + COUNT_W;
    localparam int M_TDATA_W  = ((OUT_BITS + 7) / 8) * 8;
    localparam int M_TUSER_W  = 1;

    localparam logic [COUNT_W-1:0] QUEUE_LIMIT_RESET = 8'd4;
    localparam logic [COUNT_W-1:0] LOAD_MAX          = 8'hFF;

    typedef enum logic [OP_W-1:0] {
        OP_REGISTER = 2'd0,
        OP_REPORT   = 2'd1,
        OP_ALLOCATE = 2'd2
    } op_t;

    typedef struct packed {
        logic signed [POS_W-1:0] z;
        logic signed [POS_W-1:0] y;
        logic signed [POS_W-1:0] x;
    } pos_t;

    // Input beat payload, last declared field (cell_index) in the lowest bits.
    typedef struct packed {
        logic [COUNT_W-1:0] queue_count;
        pos_t               pos;
        logic [MASK_W-1:0]  type_mask;
        logic [TYPE_W-1:0]  cell_type;
        logic               present;
        logic [IDX_W-1:0]   cell_index;
    } in_beat_t;

    // Station record memory word.
    typedef struct packed {
        logic [TYPE_W-1:0] kind;
        pos_t              pos;
    } stn_rec_t;

    // Count memory word.
    typedef struct packed {
        logic [COUNT_W-1:0] reported;
        logic [COUNT_W-1:0] allocated;
    } counts_t;

    localparam int REC_W = $bits(stn_rec_t);
    localparam int CNT_W = $bits(counts_t);

    // Cycles from station position in to squared distance out.
    localparam int DIST_LAT = 3;

endpackage

`default_nettype wire

// ----- hw/rtl/lsd_ram.sv -----
`default_nettype none

module lsd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [WIDTH-1:0]  wr_data,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ----- hw/rtl/lsd_dist.sv -----
`default_nettype none

module lsd_dist (
    input  wire logic                  clk,
    input  wire lsd_pkg::pos_t         station_pos,
    input  wire lsd_pkg::pos_t         req_pos,
    output logic [lsd_pkg::DIST_W-1:0] dist_sq
);
    import lsd_pkg::*;

    logic [POS_W-1:0] a_axis [3];
    logic [POS_W-1:0] b_axis [3];
    logic [POS_W-1:0] mag    [3];
    logic [POS_W:0]   diff   [3];
    logic [POS_W-1:0] mag_reg [3];
    logic [SQ_W-1:0]  sq_reg  [3];
    logic [DIST_W-1:0] dist_reg;

    assign a_axis[0] = station_pos.x;
    assign a_axis[1] = station_pos.y;
    assign a_axis[2] = station_pos.z;
    assign b_axis[0] = req_pos.x;
    assign b_axis[1] = req_pos.y;
    assign b_axis[2] = req_pos.z;

    // The difference of two 16-bit signed values has a magnitude that fits 16 bits.
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            diff[k] = {a_axis[k][POS_W-1], a_axis[k]} - {b_axis[k][POS_W-1], b_axis[k]};
            mag[k]  = diff[k][POS_W] ? POS_W'(~diff[k] + 1'b1) : diff[k][POS_W-1:0];
        end
    end

    always_ff @(posedge clk) begin
        for (int k = 0; k < 3; k++) begin
            mag_reg[k] <= mag[k];
            sq_reg[k]  <= mag_reg[k] * mag_reg[k];
        end
        dist_reg <= DIST_W'(sq_reg[0]) + DIST_W'(sq_reg[1]) + DIST_W'(sq_reg[2]);
    end

    assign dist_sq = dist_reg;

endmodule

`default_nettype wire

// ----- hw/rtl/least_loaded_station_dispatch.sv -----
`default_nettype none

// Least-loaded station dispatcher.
// Input beats arrive on the s_ stream; tuser carries the operation (register,
// report or allocate) and tdata the station slot, type, mask, position and
// queue count. Every accepted beat yields exactly one result beat on the m_
// stream: tuser says whether a station was found, tdata carries its slot and
// its load before the allocation. Register and report results are all zero.
// Register and report results move from the result registers to the output
// register before the next beat is taken. An allocate scans the whole station
// table through the two memories, each with a single read port, one entry a
// cycle, through the three-stage distance unit, then waits for it to drain
// and writes back the winner's count. The queue limit is written through
// cfg_wr_en and cfg_wr_data; the user must write it only while idle, which
// the block does not enforce. Reset clears the presence and report-known
// bits and sets the queue limit to four; the memories are not cleared, since
// no entry's contents are used before it has been written. A stalled receiver
// holds the result in the output register; the next input beat is still taken
// and its result waits inside.
module least_loaded_station_dispatch (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    // Input stream.
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    // tdata from bit 0: cell_index[3:0], present, cell_type[3:0], type_mask[15:0],
    // pos_x[15:0], pos_y[15:0], pos_z[15:0], queue_count[7:0], zero fill.
    input  wire logic [lsd_pkg::S_TDATA_W-1:0] s_tdata,
    // tuser from bit 0: operation[1:0].
    input  wire logic [lsd_pkg::S_TUSER_W-1:0] s_tuser,
    // Result stream.
    output logic                               m_tvalid,
    input  wire logic                          m_tready,
    // tdata from bit 0: chosen_index[3:0], chosen_load[7:0], zero fill.
    output logic      [lsd_pkg::M_TDATA_W-1:0] m_tdata,
    // tuser from bit 0: found.
    output logic      [lsd_pkg::M_TUSER_W-1:0] m_tuser,
    // Queue limit register.
    input  wire logic                          cfg_wr_en,
    input  wire logic [lsd_pkg::COUNT_W-1:0]   cfg_wr_data
);
    import lsd_pkg::*;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_WRITE,
        ST_RESULT
    } state_t;

    // Per-entry information travelling alongside the distance pipeline.
    typedef struct packed {
        logic               valid;
        logic               last;
        logic               elig;
        logic [STN_W-1:0]   idx;
        logic [COUNT_W-1:0] load;
        counts_t            counts;
    } meta_t;

    state_t             state_reg;
    logic [COUNT_W-1:0] queue_limit_reg;
    logic [NUM_STATIONS-1:0] present_reg;
    logic [NUM_STATIONS-1:0] known_reg;

    logic [MASK_W-1:0]  req_mask_reg;
    pos_t               req_pos_reg;
    logic [STN_W-1:0]   issue_cnt_reg;

    // Stage in which the memory read data is valid.
    logic               rd_valid_reg;
    logic               rd_last_reg;
    logic [STN_W-1:0]   rd_idx_reg;
    meta_t              meta_reg [DIST_LAT];

    logic               best_have_reg;
    logic [STN_W-1:0]   best_idx_reg;
    logic [COUNT_W-1:0] best_load_reg;
    logic [DIST_W-1:0]  best_dist_reg;
    counts_t            best_counts_reg;

    logic               res_found_reg;
    logic [IDX_W-1:0]   res_idx_reg;
    logic [COUNT_W-1:0] res_load_reg;

    logic               m_tvalid_reg;
    logic               m_found_reg;
    logic [IDX_W-1:0]   m_idx_reg;
    logic [COUNT_W-1:0] m_load_reg;

    in_beat_t           in_beat;
    logic               s_accept;
    logic               idx_ok;
    logic [STN_W-1:0]   in_slot;

    logic [REC_W-1:0]   rec_rd_data;
    logic [CNT_W-1:0]   cnt_rd_data;
    stn_rec_t           rec_rd;
    counts_t            cnt_rd;
    logic               rec_wr_en;
    logic               cnt_wr_en;
    logic [STN_W-1:0]   cnt_wr_addr;
    counts_t            cnt_wr_data;
    stn_rec_t           rec_wr_data;

    logic               elig_a;
    logic [COUNT_W:0]   load_sum;
    logic [COUNT_W-1:0] load_a;
    logic [DIST_W-1:0]  dist_sq;
    logic               better;
    logic [COUNT_W-1:0] alloc_inc;
    meta_t              meta_d;
    meta_t              meta_a;

    assign in_beat  = s_tdata[IN_BITS-1:0];
    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;
    assign idx_ok   = (32'(in_beat.cell_index) < NUM_STATIONS);
    assign in_slot  = STN_W'(in_beat.cell_index);

    // Station record memory: type and entry position.
    assign rec_wr_en   = s_accept && (s_tuser == OP_REGISTER) && idx_ok && in_beat.present;
    assign rec_wr_data = '{kind: in_beat.cell_type, pos: in_beat.pos};

    lsd_ram #(
        .WIDTH (REC_W),
        .DEPTH (NUM_STATIONS)
    ) u_rec_ram (
        .clk     (aclk),
        .wr_en   (rec_wr_en),
        .wr_addr (in_slot),
        .wr_data (rec_wr_data),
        .rd_addr (issue_cnt_reg),
        .rd_data (rec_rd_data)
    );

    // Count memory: written by a report, or by the allocation write-back.
    assign alloc_inc = (best_counts_reg.allocated == LOAD_MAX) ?
                       LOAD_MAX : best_counts_reg.allocated + 1'b1;

    always_comb begin
        if (state_reg == ST_WRITE) begin
            cnt_wr_en   = best_have_reg;
            cnt_wr_addr = best_idx_reg;
            cnt_wr_data = '{reported: best_counts_reg.reported, allocated: alloc_inc};
        end else begin
            cnt_wr_en   = s_accept && (s_tuser == OP_REPORT) && idx_ok;
            cnt_wr_addr = in_slot;
            cnt_wr_data = '{reported: in_beat.queue_count, allocated: '0};
        end
    end

    lsd_ram #(
        .WIDTH (CNT_W),
        .DEPTH (NUM_STATIONS)
    ) u_cnt_ram (
        .clk     (aclk),
        .wr_en   (cnt_wr_en),
        .wr_addr (cnt_wr_addr),
        .wr_data (cnt_wr_data),
        .rd_addr (issue_cnt_reg),
        .rd_data (cnt_rd_data)
    );

    assign rec_rd = rec_rd_data;
    assign cnt_rd = cnt_rd_data;

    // Eligibility and saturated load of the entry just read.
    assign load_sum = {1'b0, cnt_rd.reported} + {1'b0, cnt_rd.allocated};
    assign load_a   = load_sum[COUNT_W] ? LOAD_MAX : load_sum[COUNT_W-1:0];
    assign elig_a   = present_reg[rd_idx_reg] && known_reg[rd_idx_reg] &&
                      (cnt_rd.reported <= queue_limit_reg) &&
                      (32'(rec_rd.kind) < NUM_TYPES) && req_mask_reg[rec_rd.kind];

    assign meta_a = '{valid: rd_valid_reg, last: rd_last_reg, elig: elig_a,
                      idx: rd_idx_reg, load: load_a, counts: cnt_rd};

    lsd_dist u_dist (
        .clk         (aclk),
        .station_pos (rec_rd.pos),
        .req_pos     (req_pos_reg),
        .dist_sq     (dist_sq)
    );

    // The distance of an entry comes out together with the last meta stage.
    // Entries arrive in ascending slot order, so a strict compare keeps the lower slot.
    assign meta_d = meta_reg[DIST_LAT-1];
    assign better = !best_have_reg || (meta_d.load < best_load_reg) ||
                    ((meta_d.load == best_load_reg) && (dist_sq < best_dist_reg));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            queue_limit_reg <= QUEUE_LIMIT_RESET;
            present_reg     <= '0;
            known_reg       <= '0;
            rd_valid_reg    <= 1'b0;
            for (int k = 0; k < DIST_LAT; k++) begin
                meta_reg[k].valid <= 1'b0;
            end
            best_have_reg   <= 1'b0;
            m_tvalid_reg    <= 1'b0;
            issue_cnt_reg   <= '0;
        end else begin
            if (cfg_wr_en) begin
                queue_limit_reg <= cfg_wr_data;
            end

            if (m_tvalid_reg && m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            // Read data and distance pipeline advance every cycle.
            rd_valid_reg <= 1'b0;
            rd_last_reg  <= (32'(issue_cnt_reg) == NUM_STATIONS - 1);
            rd_idx_reg   <= issue_cnt_reg;
            meta_reg[0]  <= meta_a;
            for (int k = 1; k < DIST_LAT; k++) begin
                meta_reg[k] <= meta_reg[k-1];
            end

            if (meta_d.valid && meta_d.elig && better) begin
                best_have_reg   <= 1'b1;
                best_idx_reg    <= meta_d.idx;
                best_load_reg   <= meta_d.load;
                best_dist_reg   <= dist_sq;
                best_counts_reg <= meta_d.counts;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        res_found_reg <= 1'b0;
                        res_idx_reg   <= '0;
                        res_load_reg  <= '0;
                        state_reg     <= ST_RESULT;
                        case (s_tuser)
                            OP_REGISTER: begin
                                if (idx_ok) begin
                                    present_reg[in_slot] <= in_beat.present;
                                end
                            end
                            OP_REPORT: begin
                                if (idx_ok) begin
                                    known_reg[in_slot] <= 1'b1;
                                end
                            end
                            OP_ALLOCATE: begin
                                req_mask_reg  <= in_beat.type_mask;
                                req_pos_reg   <= in_beat.pos;
                                issue_cnt_reg <= '0;
                                best_have_reg <= 1'b0;
                                state_reg     <= ST_SCAN;
                            end
                            default: begin
                                // The unused operation only returns an empty result.
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    rd_valid_reg <= 1'b1;
                    if (32'(issue_cnt_reg) == NUM_STATIONS - 1) begin
                        state_reg <= ST_DRAIN;
                    end else begin
                        issue_cnt_reg <= issue_cnt_reg + 1'b1;
                    end
                end
                ST_DRAIN: begin
                    if (meta_d.valid && meta_d.last) begin
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    // The count memory write for the winner happens in this cycle.
                    res_found_reg <= best_have_reg;
                    res_idx_reg   <= best_have_reg ? IDX_W'(best_idx_reg) : '0;
                    res_load_reg  <= best_have_reg ? best_load_reg : '0;
                    issue_cnt_reg <= '0;
                    state_reg     <= ST_RESULT;
                end
                ST_RESULT: begin
                    if (!m_tvalid_reg || m_tready) begin
                        m_tvalid_reg <= 1'b1;
                        m_found_reg  <= res_found_reg;
                        m_idx_reg    <= res_idx_reg;
                        m_load_reg   <= res_load_reg;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = M_TUSER_W'(m_found_reg);
    assign m_tdata  = M_TDATA_W'({m_load_reg, m_idx_reg});

endmodule

`default_nettype wire

// ----- dv/lsd_dispatch_checker.sv -----
`timescale 1ns / 100ps

// Watches both streams and the limit register port, keeps its own copy of the
// station table and compares every result beat with the oldest prediction.
module lsd_dispatch_checker (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    input  wire logic                          s_tready,
    input  wire logic [lsd_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic [lsd_pkg::S_TUSER_W-1:0] s_tuser,
    input  wire logic                          m_tvalid,
    input  wire logic                          m_tready,
    input  wire logic [lsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  wire logic [lsd_pkg::M_TUSER_W-1:0] m_tuser,
    input  wire logic                          cfg_wr_en,
    input  wire logic [lsd_pkg::COUNT_W-1:0]   cfg_wr_data,
    output int                                 mismatches,
    output int                                 outstanding,
    output int                                 served,
    output int                                 unserved,
    output int                                 full_load
);
    import lsd_pkg::*;

    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic               found;
        logic [IDX_W-1:0]   slot;
        logic [COUNT_W-1:0] load;
    } dispatch_t;

    logic               occupied    [NUM_STATIONS];
    logic               report_seen [NUM_STATIONS];
    logic [TYPE_W-1:0]  kind_tab    [NUM_STATIONS];
    pos_t               entry_tab   [NUM_STATIONS];
    logic [COUNT_W-1:0] queue_tab   [NUM_STATIONS];
    logic [COUNT_W-1:0] alloc_tab   [NUM_STATIONS];
    logic [COUNT_W-1:0] limit_shadow;

    dispatch_t awaited_dispatches [$];

    // Applies one input beat to the table copy and returns the result it
    // should produce.
    function automatic dispatch_t dispatch_predict(input logic [OP_W-1:0] op,
                                                   input in_beat_t b);
        dispatch_t    r;
        logic         have;
        int           i;
        int           load;
        int           best_load;
        int           best_slot;
        longint       dx;
        longint       dy;
        longint       dz;
        logic [63:0]  reach;
        logic [63:0]  best_reach;
        r          = '0;
        have       = 1'b0;
        best_load  = 0;
        best_slot  = 0;
        best_reach = '0;
        case (op)
            OP_REGISTER: begin
                if (int'(b.cell_index) < NUM_STATIONS) begin
                    if (b.present) begin
                        occupied[b.cell_index]  = 1'b1;
                        kind_tab[b.cell_index]  = b.cell_type;
                        entry_tab[b.cell_index] = b.pos;
                    end else begin
                        occupied[b.cell_index] = 1'b0;
                    end
                end
            end
            OP_REPORT: begin
                if (int'(b.cell_index) < NUM_STATIONS) begin
                    report_seen[b.cell_index] = 1'b1;
                    queue_tab[b.cell_index]   = b.queue_count;
                    alloc_tab[b.cell_index]   = '0;
                end
            end
            OP_ALLOCATE: begin
                for (i = 0; i < NUM_STATIONS; i++) begin
                    if (occupied[i] && report_seen[i] && queue_tab[i] <= limit_shadow &&
                        int'(kind_tab[i]) < NUM_TYPES && b.type_mask[kind_tab[i]]) begin
                        load = int'(queue_tab[i]) + int'(alloc_tab[i]);
                        if (load > int'(LOAD_MAX))
                            load = int'(LOAD_MAX);
                        dx = longint'($signed(entry_tab[i].x)) - longint'($signed(b.pos.x));
                        dy = longint'($signed(entry_tab[i].y)) - longint'($signed(b.pos.y));
                        dz = longint'($signed(entry_tab[i].z)) - longint'($signed(b.pos.z));
                        reach = 64'(dx * dx + dy * dy + dz * dz);
                        if (!have || load < best_load ||
                            (load == best_load && reach < best_reach)) begin
                            have       = 1'b1;
                            best_slot  = i;
                            best_load  = load;
                            best_reach = reach;
                        end
                    end
                end
                if (have) begin
                    if (alloc_tab[best_slot] != LOAD_MAX)
                        alloc_tab[best_slot] = alloc_tab[best_slot] + 1'b1;
                    r.found = 1'b1;
                    r.slot  = IDX_W'(best_slot);
                    r.load  = COUNT_W'(best_load);
                end
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic note_mismatch(input string what, input dispatch_t want,
                                 input dispatch_t got);
        mismatches++;
        if (mismatches <= REPORT_MAX)
            $display("%t: %s: expected found=%0d slot=%0d load=%0d, got found=%0d slot=%0d load=%0d",
                     $realtime, what, want.found, want.slot, want.load,
                     got.found, got.slot, got.load);
    endtask

    always @(posedge aclk) begin
        dispatch_t got;
        dispatch_t want;
        if (!aresetn) begin
            for (int i = 0; i < NUM_STATIONS; i++) begin
                occupied[i]    = 1'b0;
                report_seen[i] = 1'b0;
                kind_tab[i]    = '0;
                entry_tab[i]   = '0;
                queue_tab[i]   = '0;
                alloc_tab[i]   = '0;
            end
            limit_shadow = QUEUE_LIMIT_RESET;
            awaited_dispatches.delete();
            mismatches = 0;
            served     = 0;
            unserved   = 0;
            full_load  = 0;
        end else begin
            if (cfg_wr_en)
                limit_shadow = cfg_wr_data;
            // Results are taken before new beats, so a result can never be
            // matched against a prediction made at the same edge.
            if (m_tvalid && m_tready) begin
                got.found = m_tuser[0];
                got.slot  = m_tdata[IDX_W-1:0];
                got.load  = m_tdata[IDX_W +: COUNT_W];
                if (awaited_dispatches.size() == 0) begin
                    note_mismatch("result beat with nothing awaited", '0, got);
                end else begin
                    want = awaited_dispatches.pop_front();
                    if (got.found !== want.found || got.slot !== want.slot ||
                        got.load !== want.load)
                        note_mismatch("result mismatch", want, got);
                end
            end
            if (s_tvalid && s_tready) begin
                want = dispatch_predict(s_tuser,
                                        in_beat_t'(s_tdata[$bits(in_beat_t)-1:0]));
                if (s_tuser == OP_ALLOCATE) begin
                    if (want.found)
                        served++;
                    else
                        unserved++;
                    if (want.found && want.load == LOAD_MAX)
                        full_load++;
                end
                awaited_dispatches.push_back(want);
            end
        end
        outstanding = awaited_dispatches.size();
    end

endmodule

// ----- dv/tb_least_loaded_station_dispatch.sv -----
`timescale 1ns / 100ps

// Testbench for the least-loaded station dispatcher.
// The top only makes stimulus and gives the verdict; the checker beside the
// block predicts every result beat and counts the failures.
module tb_least_loaded_station_dispatch;
    import lsd_pkg::*;

    // The operation code that the block must treat as a no-op.
    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

    // Cycles without any beat moving before the run is declared hung. The
    // slowest legal stretch is a settle pause plus a long sender gap plus an
    // allocate scan behind a stalled receiver.
    localparam int IDLE_LIMIT    = 2000;
    // Cycles allowed after the last result for the block to settle.
    localparam int SETTLE_CYCLES = 30;
    localparam int PHASE_ITEMS   = 190;
    localparam int FILL_ALLOCS   = 265;
    localparam int NUM_PHASES    = 5;

    logic                 aclk        = 1'b0;
    logic                 aresetn     = 1'b0;
    logic                 s_tvalid    = 1'b0;
    wire                  s_tready;
    // tdata from bit 0: cell_index, present, cell_type, type_mask, pos_x,
    // pos_y, pos_z, queue_count, zero fill.
    logic [S_TDATA_W-1:0] s_tdata     = '0;
    // tuser from bit 0: operation.
    logic [S_TUSER_W-1:0] s_tuser     = '0;
    wire                  m_tvalid;
    logic                 m_tready    = 1'b0;
    // tdata from bit 0: chosen_index, chosen_load, zero fill.
    wire  [M_TDATA_W-1:0] m_tdata;
    // tuser from bit 0: found.
    wire  [M_TUSER_W-1:0] m_tuser;
    logic                 cfg_wr_en   = 1'b0;
    logic [COUNT_W-1:0]   cfg_wr_data = '0;

    int mismatches;
    int outstanding;
    int served;
    int unserved;
    int full_load;

    int burst_left  = 0;
    int beats_sent  = 0;
    int limits_used = 0;
    int idle_cycles = 0;
    int rx_hold     = 0;
    int rx_tick     = 0;
    logic rx_calm   = 1'b0;

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    least_loaded_station_dispatch uut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    lsd_dispatch_checker checker_i (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .served      (served),
        .unserved    (unserved),
        .full_load   (full_load)
    );

    // The receiver runs in stretches, each drawn at its start as calm or not.
    // Most stretches stall at random, so that results back up inside the
    // block; some stretches never stall at all.
    always @(posedge aclk) begin
        rx_tick <= rx_tick + 1;
        if (rx_tick % 300 == 0)
            rx_calm <= ($urandom_range(0, 3) == 0);
        if (rx_hold > 0) begin
            m_tready <= 1'b0;
            rx_hold  <= rx_hold - 1;
        end else begin
            m_tready <= 1'b1;
            if (!rx_calm && $urandom_range(0, 99) < 35)
                rx_hold <= $urandom_range(1, 12);
        end
    end

    // Watchdog: any beat on either stream restarts the count.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Watchdog: no beat moved for %0d cycles, %0d results still awaited.",
                     IDLE_LIMIT, outstanding);
            $display("tb_least_loaded_station_dispatch: errors");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Offers one beat and returns at the edge that accepted it. The sender
    // works in bursts: when one is used up, a new length and a gap in front
    // of it are drawn. Some bursts are long and start without any gap.
    task automatic push_beat(input logic [OP_W-1:0] op, input in_beat_t b);
        int gap_len;
        if (burst_left == 0) begin
            if ($urandom_range(0, 5) == 0) begin
                burst_left = $urandom_range(24, 64);
                gap_len    = 0;
            end else begin
                burst_left = $urandom_range(1, 12);
                gap_len    = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 20)
                                                         : $urandom_range(0, 3);
            end
            if (gap_len > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap_len) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {{(S_TDATA_W - $bits(in_beat_t)){1'b0}}, b};
        do @(posedge aclk); while (!s_tready);
        burst_left--;
        beats_sent++;
    endtask

    // Shorthand for a fully specified beat; coordinates are given as
    // integers and keep their low sixteen bits.
    task automatic send_fields(input logic [OP_W-1:0] op, input int slot, input int pres,
                               input int kind, input int mask, input int x, input int y,
                               input int z, input int qc);
        in_beat_t b;
        b.cell_index  = IDX_W'(slot);
        b.present     = 1'(pres);
        b.cell_type   = TYPE_W'(kind);
        b.type_mask   = MASK_W'(mask);
        b.pos.x       = POS_W'(x);
        b.pos.y       = POS_W'(y);
        b.pos.z       = POS_W'(z);
        b.queue_count = COUNT_W'(qc);
        push_beat(op, b);
    endtask

    // Lowers tvalid and waits until the checker has nothing outstanding.
    // The first edge is always waited for, so that a beat taken at the
    // current edge has been counted before the test.
    task automatic drain_results();
        s_tvalid  <= 1'b0;
        burst_left = 0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // The queue limit is only changed once the block has gone quiet.
    task automatic write_limit(input int value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= COUNT_W'(value);
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        limits_used++;
    endtask

    // Coordinates either crowd a few points a metre and a half apart, which
    // makes equal loads and equal distances common, or span the full range.
    function automatic logic [POS_W-1:0] pick_coord(input logic tight);
        if (tight)
            return POS_W'(($urandom_range(0, 4) - 2) * 150);
        return POS_W'($urandom_range(0, 65535));
    endfunction

    // One random beat. Every field starts as noise, then the fields that the
    // chosen operation reads are shaped so that most allocates meet stations
    // that are present, reported and within the limit.
    task automatic random_beat(input int lim);
        in_beat_t        b;
        logic [OP_W-1:0] op;
        logic            tight;
        int              pick;
        int              qc_top;
        tight         = ($urandom_range(0, 9) < 7);
        b.cell_index  = IDX_W'($urandom_range(0, NUM_STATIONS - 1));
        b.present     = 1'($urandom_range(0, 1));
        b.cell_type   = TYPE_W'($urandom_range(0, 15));
        b.type_mask   = MASK_W'($urandom_range(0, 65535));
        b.pos.x       = pick_coord(tight);
        b.pos.y       = pick_coord(tight);
        b.pos.z       = pick_coord(tight);
        b.queue_count = COUNT_W'($urandom_range(0, 255));
        pick          = $urandom_range(0, 99);
        qc_top        = (lim + 2 > 255) ? 255 : lim + 2;
        if (pick < 45) begin
            op = OP_ALLOCATE;
            case ($urandom_range(0, 9))
                0:       b.type_mask = '1;
                1:       b.type_mask = '0;
                2, 3:    b.type_mask = MASK_W'(1) << $urandom_range(0, 15);
                default: ;
            endcase
        end else if (pick < 70) begin
            op = OP_REPORT;
            if ($urandom_range(0, 3) != 0)
                b.queue_count = COUNT_W'($urandom_range(0, qc_top));
        end else if (pick < 93) begin
            op        = OP_REGISTER;
            b.present = ($urandom_range(0, 6) != 0);
            if ($urandom_range(0, 1) == 0)
                b.cell_type = TYPE_W'($urandom_range(0, 3));
        end else begin
            op = OP_UNUSED;
        end
        push_beat(op, b);
    endtask

    initial begin
        int fill_slot;
        int fill_kind;
        int lim;
        int limit_plan [NUM_PHASES];

        limit_plan = '{0, 255, -1, 1, 4};

        // Synchronous reset, asserted from the start and never again.
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed beats under the reset limit of four.
        // An empty table gives no station, and the unused operation code
        // must leave the table alone and answer with zeros.
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0);
        send_fields(OP_UNUSED, 15, 1, 15, 16'hFFFF, -1, -1, -1, 255);
        // Two stations at opposite corners of the coordinate range; without a
        // report neither is eligible.
        send_fields(OP_REGISTER, 0, 1, 0, 0, -32768, -32768, -32768, 0);
        send_fields(OP_REGISTER, 15, 1, 15, 0, 32767, 32767, 32767, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0);
        send_fields(OP_REPORT, 0, 0, 0, 0, 0, 0, 0, 0);
        send_fields(OP_REPORT, 15, 0, 0, 0, 0, 0, 0, 0);
        // Equal loads go to the nearer station, then the lower load wins.
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'hFFFF, 32767, 32767, 32767, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'hFFFF, 32767, 32767, 32767, 0);
        // The lowest and highest type bits, and an empty mask.
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0001, 0, 0, 0, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h8000, 0, 0, 0, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0000, 0, 0, 0, 0);
        // A report for an absent station is kept; once registered, the
        // station is skipped above the limit and taken exactly at it.
        send_fields(OP_REPORT, 3, 0, 0, 0, 0, 0, 0, 5);
        send_fields(OP_REGISTER, 3, 1, 3, 0, 0, 0, 0, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0008, 0, 0, 0, 0);
        send_fields(OP_REPORT, 3, 0, 0, 0, 0, 0, 0, 4);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0008, 0, 0, 0, 0);
        // Removing a station hides it but keeps its data; registering it
        // again must not reset its counts.
        send_fields(OP_REGISTER, 15, 0, 2, 0, -5, -5, -5, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h8000, 0, 0, 0, 0);
        send_fields(OP_REGISTER, 15, 1, 15, 0, 32767, 32767, 32767, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h8000, 32767, 32767, 32767, 0);
        // Equal load and equal distance go to the lower slot.
        send_fields(OP_REGISTER, 5, 1, 6, 0, 100, -100, 7, 0);
        send_fields(OP_REGISTER, 6, 1, 6, 0, 100, -100, 7, 0);
        send_fields(OP_REPORT, 5, 0, 0, 0, 0, 0, 0, 2);
        send_fields(OP_REPORT, 6, 0, 0, 0, 0, 0, 0, 2);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0040, 0, 0, 0, 0);
        send_fields(OP_ALLOCATE, 0, 0, 0, 16'h0040, 0, 0, 0, 0);
        send_fields(OP_REPORT, 8, 0, 0, 0, 0, 0, 0, 255);

        // Saturation: with the limit fully open and a single station left,
        // enough allocates are made for the allocation count to reach 255
        // and stay there. A high report then drives the sum into the clamp.
        write_limit(int'(LOAD_MAX));
        for (int s = 0; s < NUM_STATIONS; s++)
            send_fields(OP_REGISTER, s, 0, $urandom_range(0, 15), 0, 0, 0, 0, 0);
        fill_slot = $urandom_range(0, NUM_STATIONS - 1);
        fill_kind = $urandom_range(0, 15);
        send_fields(OP_REGISTER, fill_slot, 1, fill_kind, 0, $urandom_range(0, 65535),
                    $urandom_range(0, 65535), $urandom_range(0, 65535), 0);
        send_fields(OP_REPORT, fill_slot, 0, 0, 0, 0, 0, 0, 0);
        repeat (FILL_ALLOCS)
            send_fields(OP_ALLOCATE, 0, 0, 0, $urandom_range(0, 65535) | (1 << fill_kind),
                        $urandom_range(0, 65535), $urandom_range(0, 65535),
                        $urandom_range(0, 65535), 0);
        send_fields(OP_REPORT, fill_slot, 0, 0, 0, 0, 0, 0, 252);
        repeat (6)
            send_fields(OP_ALLOCATE, 0, 0, 0, 16'hFFFF, 0, 0, 0, 0);

        // Random phases, each under its own limit: closed, fully open, a
        // random value, one, and the reset value again. Now and then the
        // sender holds off until every result is back.
        for (int p = 0; p < NUM_PHASES; p++) begin
            lim = (limit_plan[p] < 0) ? $urandom_range(2, 254) : limit_plan[p];
            write_limit(lim);
            repeat (PHASE_ITEMS) begin
                if ($urandom_range(0, 149) == 0)
                    drain_results();
                random_beat(lim);
            end
        end

        // Let the last results come out, then give the block time to show
        // any beat it should not produce.
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge aclk);

        $display("Run: %0d beats in, %0d queue-limit writes; %0d allocates served, %0d unserved.",
                 beats_sent, limits_used, served, unserved);
        $display("Run: %0d allocates at full load; %0d mismatches, %0d results left awaited.",
                 full_load, mismatches, outstanding);
        if (mismatches == 0 && outstanding == 0)
            $display("tb_least_loaded_station_dispatch: clean");
        else
            $display("tb_least_loaded_station_dispatch: errors");
        $finish;
    end

endmodule

// ----- filelist.f -----
hw/rtl/lsd_pkg.sv
hw/rtl/lsd_ram.sv
hw/rtl/lsd_dist.sv
hw/rtl/least_loaded_station_dispatch.sv
dv/lsd_dispatch_checker.sv
dv/tb_least_loaded_station_dispatch.sv
